// File: rtl/core/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gbe_pkg: shared types and codes for the graph BFS engine
// Request and response transaction layouts, request and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gbe_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VTX_W        = 7;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int DIST_W       = 6;
   localparam int EDGE_W       = 16;

   localparam logic [2:0] REQ_ADD_EDGE = 3'd0;
   localparam logic [2:0] REQ_ADD_ARC  = 3'd1;
   localparam logic [2:0] REQ_RUN_BFS  = 3'd2;
   localparam logic [2:0] REQ_QUERY    = 3'd3;
   localparam logic [2:0] REQ_PATH     = 3'd4;
   localparam logic [2:0] REQ_CLEAR    = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_NO_PATH = 2'd2;

   typedef struct packed {
      logic [2:0]       req_type;
      logic [VTX_W-1:0] vertex_a;
      logic [VTX_W-1:0] vertex_b;
   } gbe_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [VTX_W-1:0]  result_vertex;
      logic [DIST_W-1:0] distance;
      logic              reached;
      logic [EDGE_W-1:0] edge_count;
      logic              last;
   } gbe_rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/graph_bfs_engine_top.sv
// ----------------------------------------------------------------------------
// graph_bfs_engine_top: breadth-first search engine over an adjacency matrix
//
// Requests arrive on req_valid/req_ready, one transaction per request, and
// are taken only while the sequencer is idle. Results leave on
// rsp_valid/rsp_ready through an output register; a path request gives one
// transaction per path vertex, source first, with last set on the final one.
// The single adjacency memory read port and the lowest-unvisited-neighbour
// picker set the pace of a BFS.
// A stalled receiver holds the sequencer at its next result; the engine
// accepts the next request once the current one has issued all results.
// Reset empties the graph (row valid bits cleared at once), clears the BFS
// results and sets vertex_count to 64. csr_wr_en writes vertex_count.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_bfs_engine_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire gbe_pkg::gbe_req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output gbe_pkg::gbe_rsp_type     rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic [6:0]          csr_wr_data
);
   import gbe_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DISP   = 5'd1;
   localparam logic [4:0] S_ADD_RA = 5'd2;
   localparam logic [4:0] S_ADD_WA = 5'd3;
   localparam logic [4:0] S_ADD_RB = 5'd4;
   localparam logic [4:0] S_ADD_WB = 5'd5;
   localparam logic [4:0] S_ADD_OK = 5'd6;
   localparam logic [4:0] S_BFS_IN = 5'd7;
   localparam logic [4:0] S_BFS_DQ = 5'd8;
   localparam logic [4:0] S_BFS_RQ = 5'd9;
   localparam logic [4:0] S_BFS_LD = 5'd10;
   localparam logic [4:0] S_BFS_SC = 5'd11;
   localparam logic [4:0] S_Q_RD   = 5'd12;
   localparam logic [4:0] S_Q_OUT  = 5'd13;
   localparam logic [4:0] S_P_PUSH = 5'd14;
   localparam logic [4:0] S_P_NEXT = 5'd15;
   localparam logic [4:0] S_P_ERD  = 5'd16;
   localparam logic [4:0] S_P_EOUT = 5'd17;

   localparam logic [VTX_W-1:0] QMAX = VTX_W'(MAX_VERTICES);

   logic [4:0]              state_ff, state_in;
   gbe_req_type             req_ff, req_in;
   logic [VTX_W-1:0]        head_ff, head_in, tail_ff, tail_in;
   logic [IDX_W-1:0]        x_ff, x_in;
   logic [MAX_VERTICES-1:0] row_ff, row_in;
   logic [DIST_W-1:0]       xhop_ff, xhop_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] adj_vld_ff, adj_vld_in;
   logic [VTX_W-1:0]        src_ff, src_in;
   logic [EDGE_W-1:0]       edges_ff, edges_in;
   logic [VTX_W-1:0]        vcount_ff, vcount_in;
   logic [VTX_W-1:0]        walk_ff, walk_in, len_ff, len_in, k_ff, k_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   gbe_rsp_type             rsp_ff, rsp_in;

   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
   logic [DIST_W-1:0]       hop_mem [MAX_VERTICES];
   logic [VTX_W-1:0]        par_mem [MAX_VERTICES];
   logic [IDX_W-1:0]        que_mem [MAX_VERTICES];
   logic [VTX_W-1:0]        chn_mem [MAX_VERTICES];

   logic [MAX_VERTICES-1:0] adj_rd_ff;
   logic                    adj_rvld_ff;
   logic [DIST_W-1:0]       hop_rd_ff;
   logic [VTX_W-1:0]        par_rd_ff;
   logic [IDX_W-1:0]        que_rd_ff;
   logic [VTX_W-1:0]        chn_rd_ff;

   logic [IDX_W-1:0]        adj_ra, adj_wa, hop_ra, hop_wa, par_ra, par_wa;
   logic [IDX_W-1:0]        que_ra, que_wa, chn_ra, chn_wa;
   logic                    adj_we, hop_we, par_we, que_we, chn_we;
   logic [MAX_VERTICES-1:0] adj_wd;
   logic [DIST_W-1:0]       hop_wd;
   logic [VTX_W-1:0]        par_wd, chn_wd;
   logic [IDX_W-1:0]        que_wd;

   logic [VTX_W-1:0]        cnt, a_m1, b_m1, walk_m1, src_m1, chn_pos;
   logic [IDX_W-1:0]        a_idx, b_idx, pick;
   logic                    a_ok, b_ok, out_free, emit_go;
   logic [MAX_VERTICES-1:0] live_mask, cand, adj_row;
   logic [EDGE_W-1:0]       edges_inc;
   gbe_rsp_type             emit;

   assign cnt       = (vcount_ff > QMAX) ? QMAX : vcount_ff;
   assign a_m1      = req_ff.vertex_a - VTX_W'(1);
   assign b_m1      = req_ff.vertex_b - VTX_W'(1);
   assign walk_m1   = walk_ff - VTX_W'(1);
   assign src_m1    = src_ff - VTX_W'(1);
   assign chn_pos   = len_ff - VTX_W'(1) - k_ff;
   assign a_idx     = a_m1[IDX_W-1:0];
   assign b_idx     = b_m1[IDX_W-1:0];
   assign a_ok      = (req_ff.vertex_a != '0) && (req_ff.vertex_a <= cnt);
   assign b_ok      = (req_ff.vertex_b != '0) && (req_ff.vertex_b <= cnt);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign edges_inc = (edges_ff == '1) ? edges_ff : edges_ff + EDGE_W'(1);
   assign adj_row   = adj_rvld_ff ? adj_rd_ff : '0;
   assign cand      = row_ff & ~visited_ff & live_mask;

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         live_mask[i] = (VTX_W'(i) < cnt);
      end
   end

   always_comb begin
      pick = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pick = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      x_in       = x_ff;
      row_in     = row_ff;
      xhop_in    = xhop_ff;
      visited_in = visited_ff;
      adj_vld_in = adj_vld_ff;
      src_in     = src_ff;
      edges_in   = edges_ff;
      walk_in    = walk_ff;
      len_in     = len_ff;
      k_in       = k_ff;
      adj_ra = a_idx; adj_wa = a_idx; adj_we = 1'b0; adj_wd = '0;
      hop_ra = a_idx; hop_wa = '0; hop_we = 1'b0; hop_wd = '0;
      par_ra = a_idx; par_wa = '0; par_we = 1'b0; par_wd = '0;
      que_ra = head_ff[IDX_W-1:0]; que_wa = tail_ff[IDX_W-1:0];
      que_we = 1'b0; que_wd = '0;
      chn_ra = chn_pos[IDX_W-1:0]; chn_wa = len_ff[IDX_W-1:0];
      chn_we = 1'b0; chn_wd = walk_ff;
      emit_go = 1'b0;
      emit    = '{status: ST_OK, result_vertex: '0, distance: '0, reached: 1'b0,
                  edge_count: edges_ff, last: 1'b1};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (req_ff.req_type)
               REQ_ADD_EDGE, REQ_ADD_ARC: begin
                  if (!(a_ok && b_ok)) begin
                     emit.status = ST_RANGE;
                     emit_go     = out_free;
                     if (out_free) state_in = S_IDLE;
                  end else begin
                     state_in = S_ADD_RA;
                  end
               end
               REQ_RUN_BFS: begin
                  if (!a_ok) begin
                     emit.status = ST_RANGE;
                     emit_go     = out_free;
                     if (out_free) state_in = S_IDLE;
                  end else begin
                     state_in = S_BFS_IN;
                  end
               end
               REQ_QUERY: begin
                  if (!a_ok) begin
                     emit.status = ST_RANGE;
                     emit_go     = out_free;
                     if (out_free) state_in = S_IDLE;
                  end else if (src_ff == '0 || !visited_ff[a_idx]) begin
                     emit_go = out_free;
                     if (out_free) state_in = S_IDLE;
                  end else begin
                     state_in = S_Q_RD;
                  end
               end
               REQ_PATH: begin
                  if (!a_ok) begin
                     emit.status = ST_RANGE;
                     emit_go     = out_free;
                     if (out_free) state_in = S_IDLE;
                  end else if (src_ff == '0 || !visited_ff[a_idx]) begin
                     emit.status = ST_NO_PATH;
                     emit_go     = out_free;
                     if (out_free) state_in = S_IDLE;
                  end else begin
                     walk_in  = req_ff.vertex_a;
                     len_in   = '0;
                     state_in = S_P_PUSH;
                  end
               end
               REQ_CLEAR: begin
                  if (out_free) begin
                     adj_vld_in      = '0;
                     visited_in      = '0;
                     src_in          = '0;
                     edges_in        = '0;
                     emit.edge_count = '0;
                     emit_go         = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ADD_RA: begin
            adj_ra   = a_idx;
            state_in = S_ADD_WA;
         end
         S_ADD_WA: begin
            adj_we             = 1'b1;
            adj_wa             = a_idx;
            adj_wd             = adj_row | (MAX_VERTICES'(1) << b_idx);
            adj_vld_in[a_idx]  = 1'b1;
            state_in = (req_ff.req_type == REQ_ADD_EDGE) ? S_ADD_RB : S_ADD_OK;
         end
         S_ADD_RB: begin
            adj_ra   = b_idx;
            state_in = S_ADD_WB;
         end
         S_ADD_WB: begin
            adj_we            = 1'b1;
            adj_wa            = b_idx;
            adj_wd            = adj_row | (MAX_VERTICES'(1) << a_idx);
            adj_vld_in[b_idx] = 1'b1;
            state_in          = S_ADD_OK;
         end
         S_ADD_OK: begin
            if (out_free) begin
               edges_in        = edges_inc;
               emit.edge_count = edges_inc;
               emit_go         = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_BFS_IN: begin
            visited_in = MAX_VERTICES'(1) << a_idx;
            src_in     = req_ff.vertex_a;
            que_we = 1'b1; que_wa = '0;    que_wd = a_idx;
            par_we = 1'b1; par_wa = a_idx; par_wd = '0;
            hop_we = 1'b1; hop_wa = a_idx; hop_wd = '0;
            head_in  = '0;
            tail_in  = VTX_W'(1);
            state_in = S_BFS_DQ;
         end
         S_BFS_DQ: begin
            if (head_ff == tail_ff) begin
               emit_go = out_free;
               if (out_free) state_in = S_IDLE;
            end else begin
               que_ra   = head_ff[IDX_W-1:0];
               head_in  = head_ff + VTX_W'(1);
               state_in = S_BFS_RQ;
            end
         end
         S_BFS_RQ: begin
            adj_ra   = que_rd_ff;
            hop_ra   = que_rd_ff;
            x_in     = que_rd_ff;
            state_in = S_BFS_LD;
         end
         S_BFS_LD: begin
            row_in   = adj_row;
            xhop_in  = hop_rd_ff;
            state_in = S_BFS_SC;
         end
         S_BFS_SC: begin
            if (cand == '0 || tail_ff == QMAX) begin
               state_in = S_BFS_DQ;
            end else begin
               visited_in[pick] = 1'b1;
               par_we = 1'b1; par_wa = pick; par_wd = VTX_W'(x_ff) + VTX_W'(1);
               hop_we = 1'b1; hop_wa = pick; hop_wd = xhop_ff + DIST_W'(1);
               que_we = 1'b1; que_wa = tail_ff[IDX_W-1:0]; que_wd = pick;
               tail_in = tail_ff + VTX_W'(1);
            end
         end
         S_Q_RD: begin
            par_ra   = a_idx;
            hop_ra   = a_idx;
            state_in = S_Q_OUT;
         end
         S_Q_OUT: begin
            if (out_free) begin
               emit.result_vertex = par_rd_ff;
               emit.distance      = hop_rd_ff;
               emit.reached       = 1'b1;
               emit_go            = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_P_PUSH: begin
            chn_we = 1'b1;
            len_in = len_ff + VTX_W'(1);
            if (walk_ff == src_ff || len_ff == QMAX - VTX_W'(1)) begin
               k_in     = '0;
               state_in = S_P_ERD;
            end else begin
               par_ra   = walk_m1[IDX_W-1:0];
               state_in = S_P_NEXT;
            end
         end
         S_P_NEXT: begin
            walk_in  = par_rd_ff;
            state_in = S_P_PUSH;
         end
         S_P_ERD: begin
            chn_ra   = chn_pos[IDX_W-1:0];
            state_in = S_P_EOUT;
         end
         S_P_EOUT: begin
            if (out_free) begin
               emit.result_vertex = chn_rd_ff;
               emit.distance      = k_ff[DIST_W-1:0];
               emit.reached       = 1'b1;
               emit.last          = (k_ff + VTX_W'(1) == len_ff);
               emit_go            = 1'b1;
               k_in               = k_ff + VTX_W'(1);
               state_in = (k_ff + VTX_W'(1) == len_ff) ? S_IDLE : S_P_ERD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      vcount_in    = csr_wr_en ? csr_wr_data : vcount_ff;
      if (emit_go) begin
         rsp_in       = emit;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         visited_ff   <= '0;
         adj_vld_ff   <= '0;
         src_ff       <= '0;
         edges_ff     <= '0;
         vcount_ff    <= VTX_W'(64);
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         len_ff       <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         adj_vld_ff   <= adj_vld_in;
         src_ff       <= src_in;
         edges_ff     <= edges_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      x_ff    <= x_in;
      row_ff  <= row_in;
      xhop_ff <= xhop_in;
      walk_ff <= walk_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (adj_we) adj_mem[adj_wa] <= adj_wd;
      if (hop_we) hop_mem[hop_wa] <= hop_wd;
      if (par_we) par_mem[par_wa] <= par_wd;
      if (que_we) que_mem[que_wa] <= que_wd;
      if (chn_we) chn_mem[chn_wa] <= chn_wd;
   end

   always_ff @(posedge clock) begin
      adj_rd_ff   <= adj_mem[adj_ra];
      adj_rvld_ff <= adj_vld_ff[adj_ra];
      hop_rd_ff   <= hop_mem[hop_ra];
      par_rd_ff   <= par_mem[par_ra];
      que_rd_ff   <= que_mem[que_ra];
      chn_rd_ff   <= chn_mem[chn_ra];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= tail_ff) && (tail_ff <= QMAX))
      else $error("queue head passed tail or tail overflowed");

   a_visit_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BFS_DQ || state_ff == S_BFS_RQ || state_ff == S_BFS_LD ||
       state_ff == S_BFS_SC) |-> ($countones(visited_ff) == 32'(tail_ff)))
      else $error("visited set out of step with queue tail");

   a_src_seen: assert property (@(posedge clock) disable iff (reset)
      (src_ff != '0 && state_ff != S_BFS_IN) |-> visited_ff[src_m1[IDX_W-1:0]])
      else $error("bfs source not marked visited");

   a_path_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P_EOUT) |-> (k_ff < len_ff && len_ff <= QMAX))
      else $error("path emit index out of range");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while sequencer stayed idle");

endmodule

`default_nettype wire

// File: bench/graph_bfs_engine_top_tb.sv
// ----------------------------------------------------------------------------
// graph_bfs_engine_top_tb: self-checking bench for the graph BFS engine
// A directed table covers range errors, duplicates, self loops, unreached
// queries, paths and clear; random graphs follow under several vertex
// counts. Results are checked against a behavioural graph model in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_bfs_engine_top_tb;
   import gbe_pkg::*;

   typedef struct {
      gbe_req_type req;
      bit          chk;
      gbe_rsp_type rsp;
   } step_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   gbe_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   gbe_rsp_type rsp_data;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;

   logic [63:0] adj_rows [64];
   bit          seen [64];
   logic [6:0]  parent [64];
   logic [5:0]  hops [64];
   logic [6:0]  src_vertex;
   logic [15:0] edge_total;
   logic [6:0]  vcount;

   gbe_rsp_type  rsp_expect_q [$];
   step_row_type step_table [$];
   int           errors;
   int           cycles;
   bit           calm;

   graph_bfs_engine_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int active_vertices();
      return (vcount > 64) ? 64 : int'(vcount);
   endfunction

   function automatic bit in_range(logic [6:0] v);
      return (v >= 1) && (int'(v) <= active_vertices());
   endfunction

   function automatic void push_rsp(logic [1:0] st, logic [6:0] v, logic [5:0] d,
                                    logic rc, logic lst);
      gbe_rsp_type r;
      r.status        = st;
      r.result_vertex = v;
      r.distance      = d;
      r.reached       = rc;
      r.edge_count    = edge_total;
      r.last          = lst;
      rsp_expect_q.push_back(r);
   endfunction

   function automatic void graph_reset();
      for (int i = 0; i < 64; i++) begin
         adj_rows[i] = '0;
         seen[i]     = 1'b0;
         parent[i]   = '0;
         hops[i]     = '0;
      end
      src_vertex = '0;
      edge_total = '0;
      vcount     = 7'd64;
   endfunction

   function automatic void search_from(logic [6:0] s);
      int         n;
      int         head;
      int         tail;
      int         x;
      logic [5:0] wq [64];
      n = active_vertices();
      for (int i = 0; i < 64; i++) begin
         seen[i]   = 1'b0;
         parent[i] = '0;
         hops[i]   = '0;
      end
      src_vertex = s;
      seen[s-1]  = 1'b1;
      wq[0]      = 6'(s - 1);
      head       = 0;
      tail       = 1;
      while (head < tail) begin
         x = wq[head];
         head++;
         for (int w = 0; w < n; w++) begin
            if (adj_rows[x][w] && !seen[w] && tail < 64) begin
               seen[w]   = 1'b1;
               hops[w]   = hops[x] + 6'd1;
               parent[w] = 7'(x + 1);
               wq[tail]  = 6'(w);
               tail++;
            end
         end
      end
   endfunction

   function automatic void predict_graph(gbe_req_type r);
      logic [6:0] a;
      logic [6:0] b;
      logic [6:0] v;
      logic [6:0] chain [64];
      int         len;
      a = r.vertex_a;
      b = r.vertex_b;
      case (r.req_type)
         REQ_ADD_EDGE, REQ_ADD_ARC: begin
            if (!in_range(a) || !in_range(b)) begin
               push_rsp(ST_RANGE, 0, 0, 0, 1);
            end else begin
               adj_rows[a-1][b-1] = 1'b1;
               if (r.req_type == REQ_ADD_EDGE) adj_rows[b-1][a-1] = 1'b1;
               if (edge_total != 16'hFFFF) edge_total++;
               push_rsp(ST_OK, 0, 0, 0, 1);
            end
         end
         REQ_RUN_BFS: begin
            if (!in_range(a)) begin
               push_rsp(ST_RANGE, 0, 0, 0, 1);
            end else begin
               search_from(a);
               push_rsp(ST_OK, 0, 0, 0, 1);
            end
         end
         REQ_QUERY: begin
            if (!in_range(a)) push_rsp(ST_RANGE, 0, 0, 0, 1);
            else if (src_vertex == 0 || !seen[a-1]) push_rsp(ST_OK, 0, 0, 0, 1);
            else push_rsp(ST_OK, parent[a-1], hops[a-1], 1, 1);
         end
         REQ_PATH: begin
            if (!in_range(a)) begin
               push_rsp(ST_RANGE, 0, 0, 0, 1);
            end else if (src_vertex == 0 || !seen[a-1]) begin
               push_rsp(ST_NO_PATH, 0, 0, 0, 1);
            end else begin
               len = 0;
               v   = a;
               while (len < 64 && v >= 1 && v <= 64) begin
                  chain[len] = v;
                  len++;
                  if (v == src_vertex) break;
                  v = parent[v-1];
               end
               for (int k = 0; k < len; k++)
                  push_rsp(ST_OK, chain[len-1-k], hops[chain[len-1-k]-1], 1,
                           k + 1 == len);
            end
         end
         REQ_CLEAR: begin
            for (int i = 0; i < 64; i++) begin
               adj_rows[i] = '0;
               seen[i]     = 1'b0;
               parent[i]   = '0;
               hops[i]     = '0;
            end
            src_vertex = '0;
            edge_total = '0;
            push_rsp(ST_OK, 0, 0, 0, 1);
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic void add_row(logic [2:0] t, logic [6:0] a, logic [6:0] b,
                                   bit chk, gbe_rsp_type rsp);
      step_row_type s;
      s.req.req_type = t;
      s.req.vertex_a = a;
      s.req.vertex_b = b;
      s.chk          = chk;
      s.rsp          = rsp;
      step_table.push_back(s);
   endfunction

   function automatic logic [6:0] pick_vertex();
      int n;
      n = active_vertices();
      if (n == 0 || $urandom_range(0, 99) < 12) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(1, n));
   endfunction

   function automatic gbe_req_type random_req();
      gbe_req_type r;
      int          p;
      p = $urandom_range(0, 99);
      if (p < 40) r.req_type = ($urandom_range(0, 2) != 0) ? REQ_ADD_EDGE : REQ_ADD_ARC;
      else if (p < 55) r.req_type = REQ_RUN_BFS;
      else if (p < 70) r.req_type = REQ_QUERY;
      else if (p < 93) r.req_type = REQ_PATH;
      else if (p < 96) r.req_type = REQ_CLEAR;
      else r.req_type = 3'($urandom_range(6, 7));
      r.vertex_a = pick_vertex();
      r.vertex_b = pick_vertex();
      return r;
   endfunction

   task automatic send_req(gbe_req_type r, bit chk, gbe_rsp_type rsp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (chk) begin
         predict_graph(r);
         rsp_expect_q.pop_back();
         rsp_expect_q.push_back(rsp);
      end else begin
         predict_graph(r);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      vcount = value;
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int          stall;
      gbe_rsp_type e;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (rsp_expect_q.size() == 0) begin
               $display("%0t: unexpected transaction, actual %p", $time, rsp_data);
               errors++;
            end else begin
               e = rsp_expect_q.pop_front();
               if (rsp_data.status !== e.status ||
                   rsp_data.result_vertex !== e.result_vertex ||
                   rsp_data.distance !== e.distance ||
                   rsp_data.reached !== e.reached ||
                   rsp_data.edge_count !== e.edge_count ||
                   rsp_data.last !== e.last) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, e, rsp_data);
                  errors++;
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 4000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [6:0]  counts [9];
      gbe_rsp_type none_rsp;
      gbe_rsp_type z;
      z = '0;
      counts    = '{7'd64, 7'd8, 7'd1, 7'd0, 7'd127, 7'd3, 7'd64, 7'd20, 7'd64};
      errors    = 0;
      cycles    = 0;
      calm      = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      graph_reset();

      add_row(REQ_QUERY,    7'd1,   7'd0,   1, gbe_rsp_type'{ST_OK, 0, 0, 0, 0, 1});
      add_row(REQ_ADD_EDGE, 7'd0,   7'd5,   1, gbe_rsp_type'{ST_RANGE, 0, 0, 0, 0, 1});
      add_row(REQ_ADD_ARC,  7'd3,   7'd65,  1, gbe_rsp_type'{ST_RANGE, 0, 0, 0, 0, 1});
      add_row(REQ_RUN_BFS,  7'd0,   7'd0,   1, gbe_rsp_type'{ST_RANGE, 0, 0, 0, 0, 1});
      add_row(REQ_PATH,     7'd1,   7'd0,   1, gbe_rsp_type'{ST_NO_PATH, 0, 0, 0, 0, 1});
      add_row(REQ_ADD_EDGE, 7'd1,   7'd64,  0, z);
      add_row(REQ_ADD_EDGE, 7'd1,   7'd64,  0, z);
      add_row(REQ_ADD_ARC,  7'd64,  7'd2,   0, z);
      add_row(REQ_ADD_EDGE, 7'd5,   7'd5,   0, z);
      add_row(REQ_ADD_EDGE, 7'd2,   7'd5,   0, z);
      add_row(REQ_ADD_ARC,  7'd7,   7'd1,   0, z);
      add_row(REQ_RUN_BFS,  7'd1,   7'd0,   0, z);
      add_row(REQ_QUERY,    7'd64,  7'd0,   0, z);
      add_row(REQ_QUERY,    7'd5,   7'd0,   0, z);
      add_row(REQ_QUERY,    7'd7,   7'd0,   0, z);
      add_row(REQ_PATH,     7'd5,   7'd0,   0, z);
      add_row(REQ_PATH,     7'd7,   7'd0,   0, z);
      add_row(REQ_PATH,     7'd1,   7'd0,   0, z);
      add_row(3'd6,         7'd127, 7'd127, 0, z);
      add_row(3'd7,         7'd0,   7'd0,   0, z);
      add_row(REQ_RUN_BFS,  7'd64,  7'd0,   0, z);
      add_row(REQ_PATH,     7'd5,   7'd0,   0, z);
      add_row(REQ_CLEAR,    7'd0,   7'd0,   0, z);
      add_row(REQ_QUERY,    7'd5,   7'd0,   0, z);
      add_row(REQ_RUN_BFS,  7'd127, 7'd0,   0, z);
      add_row(REQ_ADD_EDGE, 7'd64,  7'd64,  0, z);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (step_table[i]) send_req(step_table[i].req, step_table[i].chk,
                                       step_table[i].rsp);

      none_rsp = '0;
      foreach (counts[p]) begin
         write_count(counts[p]);
         calm = (p == 2) || (p == 6);
         for (int k = 0; k < 39; k++) begin
            if (p == 4 && k == 20) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (rsp_expect_q.size() != 0) @(posedge clock);
            end
            send_req(random_req(), 0, none_rsp);
         end
      end

      drain();
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
